// ----- hdl/tfm_pkg.sv -----
// Package for the topic filter matcher: sizes, codes, lane types and the per-lane step function.
`default_nettype none

package tfm_pkg;

    localparam int NUM_FILTERS = 8;
    localparam int FILTER_LEN  = 64;
    localparam int AW          = $clog2(FILTER_LEN);
    localparam int CW          = $clog2(FILTER_LEN + 1);
    localparam int MASK_W      = 8;
    localparam int MASK_LANES  = (NUM_FILTERS < MASK_W) ? NUM_FILTERS : MASK_W;
    localparam int S_DATA_W    = 24;

    localparam logic [7:0] CH_MULTI  = 8'h23;
    localparam logic [7:0] CH_SINGLE = 8'h2B;
    localparam logic [7:0] CH_SEP    = 8'h2F;

    typedef enum logic [1:0] {
        FN_WR_BYTE = 2'd0,
        FN_SET_LEN = 2'd1,
        FN_TOPIC   = 2'd2,
        FN_NOP     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_HIT  = 3'b010,
        ST_MISS = 3'b100
    } lane_status_t;

    typedef struct packed {
        lane_status_t status;
        logic         adv;
    } lane_step_t;

    // One wildcard step of a lane on topic byte b, with lookahead byte nxt.
    function automatic lane_step_t lane_step(
        input lane_status_t  st,
        input logic [CW-1:0] cur,
        input logic [CW-1:0] len,
        input logic [7:0]    f,
        input logic [7:0]    b,
        input logic [7:0]    nxt,
        input logic          at_end
    );
        lane_step_t r;
        r.status = st;
        r.adv    = 1'b0;
        if (st == ST_RUN)
        begin
            if (cur >= len)
            begin
                r.status = ST_MISS;
            end
            else if (f == CH_MULTI)
            begin
                r.status = ST_HIT;
            end
            else if (f == b)
            begin
                r.adv = 1'b1;
            end
            else if (f == CH_SINGLE)
            begin
                r.adv = !at_end && (nxt == CH_SEP);
            end
            else
            begin
                r.status = ST_MISS;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/topic_filter_matcher.sv -----
// Topic filter matcher: parallel wildcard match of a streamed topic against a filter table.
// The match mask is registered into the output buffer when the last topic byte is taken.
// Throughput: one item per cycle while the skid entry is empty; every lane does its compare
// and cursor update per byte, with the filter bytes at cursor, cursor+1 and the '+' flag at
// cursor+2 prefetched from each lane's memory in the cycle before.
// Reset clears lengths (all slots off), cursors, statuses, the held byte and the output
// buffer's valid flags; filter bytes stay undefined until written.
`default_nettype none

module topic_filter_matcher
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [tfm_pkg::S_DATA_W-1:0]   s_axis_tdata,  // slot[2:0], position[8:3], value[16:9]
    input  wire logic [1:0]                     s_axis_tuser,  // func[1:0]
    input  wire logic                           s_axis_tlast,  // last
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [tfm_pkg::MASK_W-1:0]          m_axis_tdata   // match_mask[7:0]
);

    logic [2:0]                 slot;
    logic [5:0]                 position;
    logic [7:0]                 value;
    tfm_pkg::func_t             func;
    logic                       accept;
    logic                       is_wr;
    logic                       is_len;
    logic                       is_topic;
    logic                       topic_step;
    logic                       topic_last;
    logic                       pos_ok;
    logic [tfm_pkg::AW-1:0]     wr_addr;
    logic [tfm_pkg::CW-1:0]     len_sat;
    logic [tfm_pkg::NUM_FILTERS-1:0] lane_hit;
    logic [tfm_pkg::MASK_W-1:0] mask;

    logic [7:0]                 held_byte_reg;
    logic                       held_valid_reg;

    logic                       out_valid_reg;
    logic [tfm_pkg::MASK_W-1:0] out_data_reg;
    logic                       skid_valid_reg;
    logic [tfm_pkg::MASK_W-1:0] skid_data_reg;
    logic                       pop;

    assign slot     = s_axis_tdata[2:0];
    assign position = s_axis_tdata[8:3];
    assign value    = s_axis_tdata[16:9];
    assign func     = tfm_pkg::func_t'(s_axis_tuser);

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        is_wr    = 1'b0;
        is_len   = 1'b0;
        is_topic = 1'b0;
        unique case (func)
            tfm_pkg::FN_WR_BYTE: is_wr    = 1'b1;
            tfm_pkg::FN_SET_LEN: is_len   = 1'b1;
            tfm_pkg::FN_TOPIC:   is_topic = 1'b1;
            default:             ;
        endcase
    end

    assign topic_step = accept && is_topic;
    assign topic_last = topic_step && s_axis_tlast;

    assign pos_ok  = 32'(position) < tfm_pkg::FILTER_LEN;
    assign wr_addr = tfm_pkg::AW'(position);
    assign len_sat = (9'(value) > 9'(tfm_pkg::FILTER_LEN)) ?
                     tfm_pkg::CW'(tfm_pkg::FILTER_LEN) : tfm_pkg::CW'(value);

    for (genvar g = 0; g < tfm_pkg::NUM_FILTERS; g++)
    begin : g_lane
        logic [7:0]             filt_mem_reg [tfm_pkg::FILTER_LEN];
        logic                   plus_mem_reg [tfm_pkg::FILTER_LEN];
        logic [7:0]             f0_reg;
        logic [7:0]             f1_reg;
        logic                   p2_reg;
        logic [tfm_pkg::CW-1:0] cur_reg;
        logic [tfm_pkg::CW-1:0] cur_next;
        logic [tfm_pkg::CW-1:0] len_reg;
        tfm_pkg::lane_status_t  status_reg;
        tfm_pkg::lane_status_t  status_next;
        tfm_pkg::lane_step_t    s1;
        tfm_pkg::lane_step_t    s2;
        logic [tfm_pkg::CW-1:0] c1;
        logic [tfm_pkg::CW-1:0] c2;
        logic [7:0]             f_c1;
        logic                   plus_c1n;
        logic                   plus_c2;
        logic                   hit;
        logic                   slot_hit;
        logic                   lane_wr;
        logic                   lane_len_wr;
        logic [tfm_pkg::AW-1:0] a0;
        logic [tfm_pkg::AW-1:0] a1;
        logic [tfm_pkg::AW-1:0] a2;

        assign slot_hit    = 32'(slot) == g;
        assign lane_wr     = accept && is_wr && slot_hit && pos_ok;
        assign lane_len_wr = accept && is_len && slot_hit;
        assign lane_hit[g] = hit;

        always_comb
        begin
            // step on the held byte, lookahead is the incoming byte
            if (held_valid_reg)
            begin
                s1 = tfm_pkg::lane_step(status_reg, cur_reg, len_reg, f0_reg,
                                        held_byte_reg, value, 1'b0);
            end
            else
            begin
                s1.status = status_reg;
                s1.adv    = 1'b0;
            end
            c1       = cur_reg + tfm_pkg::CW'(s1.adv);
            f_c1     = s1.adv ? f1_reg : f0_reg;
            plus_c1n = s1.adv ? p2_reg : (f1_reg == tfm_pkg::CH_SINGLE);

            // end-of-topic step on the last byte
            s2      = tfm_pkg::lane_step(s1.status, c1, len_reg, f_c1, value, 8'h00, 1'b1);
            c2      = c1 + tfm_pkg::CW'(s2.adv);
            plus_c2 = s2.adv ? plus_c1n : (f_c1 == tfm_pkg::CH_SINGLE);

            hit = (len_reg != '0) &&
                  ((s2.status == tfm_pkg::ST_HIT) ||
                   ((s2.status == tfm_pkg::ST_RUN) && ((c2 >= len_reg) || plus_c2)));

            cur_next    = cur_reg;
            status_next = status_reg;
            if (topic_step)
            begin
                if (s_axis_tlast)
                begin
                    cur_next    = '0;
                    status_next = tfm_pkg::ST_RUN;
                end
                else
                begin
                    cur_next    = c1;
                    status_next = s1.status;
                end
            end

            a0 = tfm_pkg::AW'(cur_next);
            a1 = a0 + tfm_pkg::AW'(1);
            a2 = a0 + tfm_pkg::AW'(2);
        end

        // filter store and prefetch, with write bypass
        always_ff @(posedge clk)
        begin
            if (lane_wr)
            begin
                filt_mem_reg[wr_addr] <= value;
                plus_mem_reg[wr_addr] <= (value == tfm_pkg::CH_SINGLE);
            end
            f0_reg <= (lane_wr && (wr_addr == a0)) ? value : filt_mem_reg[a0];
            f1_reg <= (lane_wr && (wr_addr == a1)) ? value : filt_mem_reg[a1];
            p2_reg <= (lane_wr && (wr_addr == a2)) ? (value == tfm_pkg::CH_SINGLE)
                                                   : plus_mem_reg[a2];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cur_reg    <= '0;
                status_reg <= tfm_pkg::ST_RUN;
                len_reg    <= '0;
            end
            else
            begin
                cur_reg    <= cur_next;
                status_reg <= status_next;
                if (lane_len_wr)
                begin
                    len_reg <= len_sat;
                end
            end
        end
    end

    always_comb
    begin
        mask = '0;
        for (int i = 0; i < tfm_pkg::MASK_LANES; i++)
        begin
            mask[i] = lane_hit[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (topic_step)
        begin
            if (s_axis_tlast)
            begin
                held_byte_reg  <= '0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                held_byte_reg  <= value;
                held_valid_reg <= 1'b1;
            end
        end
    end

    // two-entry output buffer: result register plus skid
    assign pop = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (topic_last)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (topic_last)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= mask;
            end
            else
            begin
                skid_data_reg <= mask;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
